### sv/xxh_pkg.sv
`default_nettype none

package xxh_pkg;

	// XXH32 primes
	localparam logic [31:0] XP1 = 32'd2654435761;
	localparam logic [31:0] XP2 = 32'd2246822519;
	localparam logic [31:0] XP3 = 32'd3266489917;
	localparam logic [31:0] XP4 = 32'd668265263;
	localparam logic [31:0] XP5 = 32'd374761393;

	// lane 0 start offset, wraps modulo 2^32
	localparam logic [31:0] LANE0_OFS = XP1 + XP2;

	// rotate and shift amounts
	localparam int unsigned ROT_LANE  = 13;
	localparam int unsigned ROT_TAIL4 = 17;
	localparam int unsigned ROT_TAIL1 = 11;
	localparam int unsigned ROT_M0    = 1;
	localparam int unsigned ROT_M1    = 7;
	localparam int unsigned ROT_M2    = 12;
	localparam int unsigned ROT_M3    = 18;
	localparam int unsigned SHR_AV1   = 15;
	localparam int unsigned SHR_AV2   = 13;
	localparam int unsigned SHR_AV3   = 16;

	// which kind of round the shared multiply/rotate path is running
	typedef enum logic [1:0] {
		RK_LANE,
		RK_TAIL4,
		RK_TAIL1
	} kind_t;

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_BYTE,
		OP_MUL1,
		OP_ROT,
		OP_MUL2,
		OP_MRG0,
		OP_MRG1,
		OP_MRG2,
		OP_XS15,
		OP_MULP2,
		OP_XS13,
		OP_MULP3,
		OP_FINAL
	} op_t;

	typedef struct packed {
		op_t   op;
		kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_full;
		logic lane_last;
		logic tail4_ok;
		logic tail1_ok;
	} dp_stat_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
		return (v << r) | (v >> (32 - r));
	endfunction

endpackage

`default_nettype wire

### sv/xxh_ctrl.sv
`default_nettype none

module xxh_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic              has_byte,
	input  wire logic              last_item,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output xxh_pkg::dp_cmd_t       cmd,
	input  wire xxh_pkg::dp_stat_t st
);
	import xxh_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_RMUL  = 13'b0000000000010,
		ST_RROT  = 13'b0000000000100,
		ST_RFIN  = 13'b0000000001000,
		ST_MRG0  = 13'b0000000010000,
		ST_MRG1  = 13'b0000000100000,
		ST_MRG2  = 13'b0000001000000,
		ST_TCHK  = 13'b0000010000000,
		ST_XS15  = 13'b0000100000000,
		ST_MULP2 = 13'b0001000000000,
		ST_XS13  = 13'b0010000000000,
		ST_MULP3 = 13'b0100000000000,
		ST_FINAL = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;
	logic   last_q, last_d;
	logic   m_valid_q;
	logic   accept;
	logic   fire_final;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;

	// next state and datapath command
	always_comb begin
		state_d    = state_q;
		kind_d     = kind_q;
		last_d     = last_q;
		cmd.op     = OP_NONE;
		cmd.kind   = kind_q;
		fire_final = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (has_byte) begin
						cmd.op = OP_BYTE;
						if (st.fill_full) begin
							state_d = ST_RMUL;
							kind_d  = RK_LANE;
							last_d  = last_item;
						end else if (last_item) begin
							state_d = ST_MRG0;
						end
					end else if (last_item) begin
						state_d = ST_MRG0;
					end
				end
			end
			ST_RMUL: begin
				cmd.op  = OP_MUL1;
				state_d = ST_RROT;
			end
			ST_RROT: begin
				cmd.op  = OP_ROT;
				state_d = ST_RFIN;
			end
			ST_RFIN: begin
				cmd.op = OP_MUL2;
				if (kind_q == RK_LANE) begin
					if (st.lane_last) begin
						state_d = last_q ? ST_MRG0 : ST_IDLE;
					end else begin
						state_d = ST_RMUL;
					end
				end else begin
					state_d = ST_TCHK;
				end
			end
			ST_MRG0: begin
				cmd.op  = OP_MRG0;
				state_d = ST_MRG1;
			end
			ST_MRG1: begin
				cmd.op  = OP_MRG1;
				state_d = ST_MRG2;
			end
			ST_MRG2: begin
				cmd.op  = OP_MRG2;
				state_d = ST_TCHK;
			end
			ST_TCHK: begin
				if (st.tail4_ok) begin
					kind_d  = RK_TAIL4;
					state_d = ST_RMUL;
				end else if (st.tail1_ok) begin
					kind_d  = RK_TAIL1;
					state_d = ST_RMUL;
				end else begin
					state_d = ST_XS15;
				end
			end
			ST_XS15: begin
				cmd.op  = OP_XS15;
				state_d = ST_MULP2;
			end
			ST_MULP2: begin
				cmd.op  = OP_MULP2;
				state_d = ST_XS13;
			end
			ST_XS13: begin
				cmd.op  = OP_XS13;
				state_d = ST_MULP3;
			end
			ST_MULP3: begin
				cmd.op  = OP_MULP3;
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				// hold until the output register is free
				if (!m_valid_q || m_tready) begin
					cmd.op     = OP_FINAL;
					fire_final = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kind_q    <= RK_LANE;
			last_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			last_q  <= last_d;
			if (fire_final) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// a pending digest is never overwritten
	a_final_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) && m_valid_q && !m_tready |=> (state_q == ST_FINAL))
		else $error("digest step left while output register full");

	// sixteenth byte of a stripe starts the lane rounds
	a_stripe_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && has_byte && st.fill_full |=> (state_q == ST_RMUL) && (kind_q == RK_LANE))
		else $error("full stripe did not start lane rounds");

	// end of message without a stripe goes straight to the merge
	a_last_merge: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_item && !(has_byte && st.fill_full) |=> (state_q == ST_MRG0))
		else $error("last beat did not start digest");

	// output valid only rises out of the final step
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == ST_FINAL))
		else $error("digest valid raised outside final step");

endmodule

`default_nettype wire

### sv/xxh_dp.sv
`default_nettype none

module xxh_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [31:0]      cfg_wr_data,
	input  wire logic [7:0]       data_byte,
	input  wire xxh_pkg::dp_cmd_t cmd,
	output xxh_pkg::dp_stat_t     st,
	output logic [31:0]           digest
);
	import xxh_pkg::*;

	// control state
	logic [31:0] seed_q;
	logic [31:0] acc_q [4];
	logic [3:0]  fill_q;
	logic [31:0] len_q;
	logic        seen_q;
	logic [4:0]  pos_q;

	// payload
	logic [31:0] word_q [4];
	logic [31:0] prod_q;
	logic [31:0] t_q;
	logic [31:0] h_q;
	logic [31:0] digest_q;

	logic [31:0] word_rd;
	logic [7:0]  byte_rd;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_lo;
	logic [31:0] rot_base;
	logic [31:0] rot_sum;
	logic [31:0] rot_res;

	// one read port into the stripe words
	assign word_rd = word_q[pos_q[3:2]];
	assign byte_rd = word_rd[{pos_q[1:0], 3'b000} +: 8];

	// status to the controller
	assign st.fill_full = (fill_q == 4'd15);
	assign st.lane_last = (pos_q[3:2] == 2'd3);
	assign st.tail4_ok  = ((6'(pos_q) + 6'd4) <= 6'(fill_q));
	assign st.tail1_ok  = (pos_q < 5'(fill_q));

	assign digest = digest_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = h_q;
		mul_b = XP1;
		case (cmd.op)
			OP_MUL1: begin
				case (cmd.kind)
					RK_LANE: begin
						mul_a = word_rd;
						mul_b = XP2;
					end
					RK_TAIL4: begin
						mul_a = word_rd;
						mul_b = XP3;
					end
					default: begin
						mul_a = {24'd0, byte_rd};
						mul_b = XP5;
					end
				endcase
			end
			OP_MUL2: begin
				mul_a = t_q;
				mul_b = (cmd.kind == RK_TAIL4) ? XP4 : XP1;
			end
			OP_MULP2: begin
				mul_b = XP2;
			end
			OP_MULP3: begin
				mul_b = XP3;
			end
			default: begin
				mul_a = h_q;
				mul_b = XP1;
			end
		endcase
	end

	assign mul_lo = mul_a * mul_b;

	// add and rotate step of a round
	assign rot_base = (cmd.kind == RK_LANE) ? acc_q[pos_q[3:2]] : h_q;
	assign rot_sum  = rot_base + prod_q;

	always_comb begin
		case (cmd.kind)
			RK_LANE:  rot_res = rotl32(rot_sum, ROT_LANE);
			RK_TAIL4: rot_res = rotl32(rot_sum, ROT_TAIL4);
			default:  rot_res = rotl32(rot_sum, ROT_TAIL1);
		endcase
	end

	// seed, lanes and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= 32'd0;
			acc_q[0] <= LANE0_OFS;
			acc_q[1] <= XP2;
			acc_q[2] <= 32'd0;
			acc_q[3] <= 32'd0 - XP1;
			fill_q   <= 4'd0;
			len_q    <= 32'd0;
			seen_q   <= 1'b0;
			pos_q    <= 5'd0;
		end else if (cfg_wr_en) begin
			seed_q   <= cfg_wr_data;
			acc_q[0] <= cfg_wr_data + LANE0_OFS;
			acc_q[1] <= cfg_wr_data + XP2;
			acc_q[2] <= cfg_wr_data;
			acc_q[3] <= cfg_wr_data - XP1;
			fill_q   <= 4'd0;
			len_q    <= 32'd0;
			seen_q   <= 1'b0;
			pos_q    <= 5'd0;
		end else begin
			case (cmd.op)
				OP_BYTE: begin
					fill_q <= fill_q + 4'd1;
					len_q  <= len_q + 32'd1;
					pos_q  <= 5'd0;
					if (fill_q == 4'd15) begin
						seen_q <= 1'b1;
					end
				end
				OP_MUL2: begin
					if (cmd.kind == RK_LANE) begin
						acc_q[pos_q[3:2]] <= mul_lo;
					end
					pos_q <= pos_q + ((cmd.kind == RK_TAIL1) ? 5'd1 : 5'd4);
				end
				OP_MRG0: begin
					pos_q <= 5'd0;
				end
				OP_FINAL: begin
					// back to the seeded start
					acc_q[0] <= seed_q + LANE0_OFS;
					acc_q[1] <= seed_q + XP2;
					acc_q[2] <= seed_q;
					acc_q[3] <= seed_q - XP1;
					fill_q   <= 4'd0;
					len_q    <= 32'd0;
					seen_q   <= 1'b0;
					pos_q    <= 5'd0;
				end
				default: begin
				end
			endcase
		end
	end

	// stripe bytes and hash working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_BYTE: begin
				word_q[fill_q[3:2]][{fill_q[1:0], 3'b000} +: 8] <= data_byte;
			end
			OP_MUL1: begin
				prod_q <= mul_lo;
			end
			OP_ROT: begin
				t_q <= rot_res;
			end
			OP_MUL2: begin
				if (cmd.kind != RK_LANE) begin
					h_q <= mul_lo;
				end
			end
			OP_MRG0: begin
				h_q <= seen_q ? (rotl32(acc_q[0], ROT_M0) + rotl32(acc_q[1], ROT_M1))
				              : (seed_q + XP5);
			end
			OP_MRG1: begin
				if (seen_q) begin
					h_q <= h_q + rotl32(acc_q[2], ROT_M2) + rotl32(acc_q[3], ROT_M3);
				end
			end
			OP_MRG2: begin
				h_q <= h_q + len_q;
			end
			OP_XS15: begin
				h_q <= h_q ^ (h_q >> SHR_AV1);
			end
			OP_MULP2: begin
				h_q <= mul_lo;
			end
			OP_XS13: begin
				h_q <= h_q ^ (h_q >> SHR_AV2);
			end
			OP_MULP3: begin
				h_q <= mul_lo;
			end
			OP_FINAL: begin
				digest_q <= h_q ^ (h_q >> SHR_AV3);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/xxh32_stream_hash.sv
// channel   dir  handshake          payload
// cfg       in   cfg_wr_en          cfg_wr_data = hash_seed
// s (in)    in   s_tvalid/s_tready  s_tdata = data_byte, s_tuser = has_byte, s_tlast = last_item
// m (out)   out  m_tvalid/m_tready  m_tdata = digest
//
// The beat that completes a 16-byte stripe then runs four lanes, three steps
// each through the one shared multiplier; no beat is taken meanwhile.
// A last beat runs the merge, then a check and a round per tail step (up to 3
// word and 3 byte steps), a closing check and the avalanche steps before the digest is loaded.
// Reset gives the start state for seed 0; no clearing pass.
// The digest waits in an output register while the next message streams in;
// a second digest holds in its final step until that register is taken.
`default_nettype none

module xxh32_stream_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,  // hash_seed
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,      // [7:0] data_byte
	input  wire logic        s_tuser,      // [0] has_byte
	input  wire logic        s_tlast,      // last_item
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata       // [31:0] digest
);
	import xxh_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	xxh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.has_byte  (s_tuser),
		.last_item (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.st        (st)
	);

	xxh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_byte   (s_tdata),
		.cmd         (cmd),
		.st          (st),
		.digest      (m_tdata)
	);

endmodule

`default_nettype wire

### test/xxh32_stream_hash_tb.sv
`timescale 1ns / 1ps

module xxh32_stream_hash_tb;
	import xxh_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned N_PHASES    = 12;
	localparam int unsigned PHASE_ITEMS = 84;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_WAIT  = 60;

	// one byte beat as offered on the slave side
	typedef struct packed {
		logic       has_byte;
		logic [7:0] data_byte;
		logic       last_item;
	} byte_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	xxh32_stream_hash u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),      // [7:0] data_byte
		.s_tuser     (s_tuser),      // [0] has_byte
		.s_tlast     (s_tlast),      // last_item
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)       // [31:0] digest
	);

	byte_beat_t  beat_q[$];
	logic [31:0] digest_q[$];

	logic        in_taken = 1'b0;
	bit          no_idle = 1'b0;
	bit          hold_request = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned cycle_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned beats_in = 0;
	int unsigned digests_ok = 0;
	int unsigned msgs_seen = 0;
	int unsigned seed_writes = 0;

	// hash state mirrored in the testbench
	logic [31:0] seed_r;
	logic [31:0] lane_r[4];
	logic [7:0]  stripe_b[16];
	int unsigned fill_n;
	logic [31:0] msg_len;
	bit          stripe_done;

	function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned r);
		return (v << r) | (v >> (32 - r));
	endfunction

	function automatic logic [31:0] word_at(input int unsigned p);
		return {stripe_b[p + 3], stripe_b[p + 2], stripe_b[p + 1], stripe_b[p]};
	endfunction

	function automatic void restart_message();
		lane_r[0] = seed_r + XP1 + XP2;
		lane_r[1] = seed_r + XP2;
		lane_r[2] = seed_r;
		lane_r[3] = seed_r - XP1;
		fill_n = 0;
		msg_len = '0;
		stripe_done = 1'b0;
	endfunction

	function automatic void absorb_stripe();
		for (int k = 0; k < 4; k++) begin
			lane_r[k] = rol(lane_r[k] + word_at(4 * k) * XP2, ROT_LANE) * XP1;
		end
	endfunction

	// merge or seed start, length, word and byte tail steps, avalanche
	function automatic logic [31:0] tail_digest();
		logic [31:0] h;
		int unsigned pos;
		pos = 0;
		if (stripe_done)
			h = rol(lane_r[0], ROT_M0) + rol(lane_r[1], ROT_M1) +
				rol(lane_r[2], ROT_M2) + rol(lane_r[3], ROT_M3);
		else
			h = seed_r + XP5;
		h = h + msg_len;
		while (pos + 4 <= fill_n) begin
			h = h + word_at(pos) * XP3;
			h = rol(h, ROT_TAIL4) * XP4;
			pos += 4;
		end
		while (pos < fill_n) begin
			h = h + stripe_b[pos] * XP5;
			h = rol(h, ROT_TAIL1) * XP1;
			pos++;
		end
		h = h ^ (h >> SHR_AV1);
		h = h * XP2;
		h = h ^ (h >> SHR_AV2);
		h = h * XP3;
		h = h ^ (h >> SHR_AV3);
		return h;
	endfunction

	function automatic void absorb_beat(input byte_beat_t b);
		if (b.has_byte) begin
			stripe_b[fill_n] = b.data_byte;
			fill_n++;
			msg_len = msg_len + 1;
			if (fill_n == 16) begin
				absorb_stripe();
				fill_n = 0;
				stripe_done = 1'b1;
			end
		end
		if (b.last_item) begin
			digest_q.push_back(tail_digest());
			msgs_seen++;
			restart_message();
		end
	endfunction

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// sender: next beat at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (beat_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 37)) begin
				byte_beat_t b;
				b = beat_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= b.has_byte;
				s_tdata  <= b.data_byte;
				s_tlast  <= b.last_item;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		int unsigned hold_left;
		if (hold_request && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 37);
		end
	end

	// monitor: predict on input beats, check on output beats
	always @(posedge clk) begin
		logic [31:0] want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digests outstanding",
				cycle_cnt, digest_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
		in_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			absorb_beat('{has_byte: s_tuser, data_byte: s_tdata, last_item: s_tlast});
			beats_in++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				$error("digest: expected none, actual %08h", m_tdata);
				err_cnt++;
			end else begin
				want = digest_q.pop_front();
				if (m_tdata !== want) begin
					$error("digest: expected %08h, actual %08h", want, m_tdata);
					err_cnt++;
				end else begin
					digests_ok++;
				end
			end
		end
	end

	// stimulus helpers
	task automatic put_beat(input logic has, input logic [7:0] d, input logic last,
			inout int unsigned cnt);
		beat_q.push_back('{has_byte: has, data_byte: d, last_item: last});
		if (has || last)
			cnt++;
	endtask

	// a message of len bytes; ends on its last byte or on a separate empty finish
	task automatic put_message(input int unsigned len, input bit end_on_byte,
			inout int unsigned cnt);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 10)
				put_beat(1'b0, 8'($urandom), 1'b0, cnt);
			put_beat(1'b1, 8'($urandom), end_on_byte && (i == len - 1), cnt);
		end
		if (!end_on_byte || len == 0)
			put_beat(1'b0, 8'($urandom), 1'b1, cnt);
	endtask

	task automatic write_seed(input logic [31:0] s);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= s;
		seed_r = s;
		restart_message();
		seed_writes++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// sender stops until the block has delivered everything
	task automatic drain();
		wait (beat_q.size() == 0 && !s_tvalid && digest_q.size() == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	initial begin
		int unsigned cnt;
		int unsigned len;
		logic [31:0] seeds[6];

		seed_r = '0;
		foreach (stripe_b[i])
			stripe_b[i] = '0;
		restart_message();
		seeds[0] = 32'hFFFF_FFFF;
		seeds[1] = $urandom;
		seeds[2] = 32'h8000_0000;
		seeds[3] = 32'h0000_0001;
		seeds[4] = $urandom;
		seeds[5] = 32'h0000_0000;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: empty message, single bytes, word tail, exact stripe
		cnt = 0;
		write_seed(32'h0000_0000);
		put_beat(1'b0, 8'h00, 1'b1, cnt);
		put_beat(1'b1, 8'hFF, 1'b1, cnt);
		put_beat(1'b0, 8'hA5, 1'b0, cnt);
		put_beat(1'b1, 8'h00, 1'b1, cnt);
		for (int i = 0; i < 4; i++)
			put_beat(1'b1, 8'(8'h11 * (i + 1)), i == 3, cnt);
		for (int i = 0; i < 16; i++)
			put_beat(1'b1, (i % 2 == 0) ? 8'hFF : 8'h00, 1'b0, cnt);
		put_beat(1'b0, 8'h00, 1'b1, cnt);
		drain();

		// random phases: seed changes, two burst phases, one long receiver hold-off
		for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
			if (ph % 2 == 0)
				write_seed(seeds[ph / 2]);
			no_idle = (ph == 3) || (ph == 5);
			hold_request = (ph == 5);
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 8) begin
					put_beat(1'($urandom), 8'($urandom), 1'($urandom), cnt);
				end else begin
					if (ph == 5)
						len = $urandom_range(0, 5);
					else if ($urandom_range(0, 99) < 20)
						len = $urandom_range(21, 70);
					else
						len = $urandom_range(0, 20);
					put_message(len, 1'($urandom_range(0, 1)), cnt);
				end
			end
			// leave a partial message for the next seed write to abandon
			if (ph % 2 == 1) begin
				len = $urandom_range(1, 20);
				for (int unsigned i = 0; i < len; i++)
					put_beat(1'b1, 8'($urandom), 1'b0, cnt);
			end
			drain();
		end
		no_idle = 1'b0;
		hold_request = 1'b0;

		$display("covered %0d input beats, %0d digests checked over %0d messages",
			beats_in, digests_ok, msgs_seen);
		$display("seed writes: %0d, including all-zeros, all-ones and mid-message",
			seed_writes);
		if (err_cnt == 0 && digest_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### xxh32_stream_hash.f
sv/xxh_pkg.sv
sv/xxh_ctrl.sv
sv/xxh_dp.sv
sv/xxh32_stream_hash.sv
test/xxh32_stream_hash_tb.sv
